FILE: rtl/des_block_decrypt_top_macros.svh
// Assertion macros shared by the checker of the DES decryption block.
// No dependencies; included by the checker file.
`ifndef DES_BLOCK_DECRYPT_TOP_MACROS_SVH
`define DES_BLOCK_DECRYPT_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DESDEC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("DES decrypt check failed");

// Checks that a condition implies another in the next cycle.
`define DESDEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("DES decrypt check failed");

`endif

FILE: rtl/desdec_pkg.sv
// Constants and functions for DES decryption: permutation tables, S-boxes,
// the key schedule and the Feistel round function. No dependencies.
package desdec_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Left rotation per encryption round; decryption undoes them in reverse.
  localparam logic [1:0] ROT_TAB [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
  };

  // Table positions count from 1 at the most significant bit.
  function automatic logic [63:0] init_perm(input logic [63:0] x);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[6'(63 - i)] = x[6'(7'd64 - IP_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [63:0] final_perm(input logic [63:0] x);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) begin
      res[6'(63 - i)] = x[6'(7'd64 - FP_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [55:0] key_pc1(input logic [63:0] k);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) begin
      res[6'(55 - i)] = k[6'(7'd64 - PC1_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] key_pc2(input logic [55:0] cd);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[6'(47 - i)] = cd[6'(6'd56 - PC2_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [47:0] expand(input logic [31:0] r);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) begin
      res[6'(47 - i)] = r[5'(6'd32 - E_TAB[i])];
    end
    return res;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] s);
    logic [31:0] res;
    for (int i = 0; i < 32; i++) begin
      res[5'(31 - i)] = s[5'(6'd32 - P_TAB[i])];
    end
    return res;
  endfunction

  // The S-box row comes from the outer bits of each six-bit group.
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s;
    x = expand(r) ^ k;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      six = x[47 - 6 * i -: 6];
      s[31 - 4 * i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    return p_perm(s);
  endfunction

  function automatic logic [27:0] rot_right(input logic [27:0] v, input logic [1:0] amt);
    logic [27:0] res;
    if (amt == 2'd2) begin
      res = {v[1:0], v[27:2]};
    end else begin
      res = {v[0], v[27:1]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/des_block_decrypt_top.sv
// DES decryption block: a single Feistel round unit and key schedule stepped
// sixteen times per block. Depends on desdec_pkg.

// One ciphertext block is decrypted under the key in the cipher_key register.
// After a transaction is taken on the input, the round unit steps through the
// Feistel rounds, with the round keys K16 down to K1 produced on the fly by
// rotating the C and D halves of the key right. The plaintext is registered in
// the output register at the end of the last round, and the input is ready
// again in the cycle in which the plaintext appears, so a new block can start
// only once the previous block is done. A result still waiting on the output
// does not block the next block until that block reaches its last round. The
// key must only be written while no block is in progress.
module des_block_decrypt_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cipher_key_we_i,
  input  logic [63:0] cipher_key_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] cipher_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] plain_block_o
);

  desdec_pkg::state_e state_q, state_d;

  logic [63:0] key_q;
  logic [31:0] left_q, left_d;
  logic [31:0] right_q, right_d;
  logic [27:0] c_q, c_d;
  logic [27:0] d_q, d_d;
  logic [3:0]  rnd_q, rnd_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] plain_q, plain_d;

  logic        in_accept;
  logic        last_rnd;
  logic        advance;
  logic [63:0] ip_blk;
  logic [55:0] cd_init;
  logic [47:0] subkey;
  logic [31:0] round_right;
  logic [1:0]  rot_amt;

  assign in_accept   = in_valid_i && (state_q == desdec_pkg::ST_IDLE);
  assign last_rnd    = (rnd_q == 4'd15);
  assign advance     = !(last_rnd && out_valid_q && !out_ready_i);
  assign ip_blk      = desdec_pkg::init_perm(cipher_block_i);
  assign cd_init     = desdec_pkg::key_pc1(key_q);
  assign subkey      = desdec_pkg::key_pc2({c_q, d_q});
  assign round_right = left_q ^ desdec_pkg::feistel(right_q, subkey);
  assign rot_amt     = desdec_pkg::ROT_TAB[~rnd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= desdec_pkg::ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      key_q       <= '0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
      if (cipher_key_we_i) begin
        key_q <= cipher_key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
    c_q     <= c_d;
    d_q     <= d_d;
    plain_q <= plain_d;
  end

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    left_d      = left_q;
    right_d     = right_q;
    c_d         = c_q;
    d_d         = d_q;
    plain_d     = plain_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    case (state_q)
      desdec_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept) begin
          left_d  = ip_blk[63:32];
          right_d = ip_blk[31:0];
          c_d     = cd_init[55:28];
          d_d     = cd_init[27:0];
          rnd_d   = '0;
          state_d = desdec_pkg::ST_RUN;
        end
      end
      desdec_pkg::ST_RUN: begin
        if (advance) begin
          left_d  = right_q;
          right_d = round_right;
          c_d     = desdec_pkg::rot_right(c_q, rot_amt);
          d_d     = desdec_pkg::rot_right(d_q, rot_amt);
          rnd_d   = rnd_q + 4'd1;
          if (last_rnd) begin
            plain_d     = desdec_pkg::final_perm({round_right, right_q});
            out_valid_d = 1'b1;
            state_d     = desdec_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = desdec_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign plain_block_o = plain_q;

endmodule

FILE: rtl/des_block_decrypt_checker.sv
// Port-level checks for the DES decryption block, bound to its top level.
// Depends on des_block_decrypt_top_macros.svh and des_block_decrypt_top.
`include "des_block_decrypt_top_macros.svh"

module des_block_decrypt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] plain_block_o
);

  // A stalled result transaction keeps its data.
  `DESDEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(plain_block_o))

  // Once a block is taken, the block is busy with its rounds.
  `DESDEC_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A new result only ever follows a cycle of round work.
  `DESDEC_ASSERT(a_result_from_run, clk_i, rst_ni, !$rose(out_valid_o) || $past(!in_ready_o))

endmodule

bind des_block_decrypt_top des_block_decrypt_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .plain_block_o (plain_block_o)
);
